/* rtl/core/spg_pkg.sv */
package spg_pkg;
    localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;

    typedef enum logic [1:0] {
        MUL_A,
        MUL_B
    } t_mul_sel;
endpackage

/* rtl/core/seeded_permutation_generator.sv */
// Sequence: accept, identity fill of the table, then for each swap step ADV, two
// multiplies on the shared multiplier, a bit-serial modulo, two table reads and two
// table writes; then each row is read from the table and emitted, holding while stalled.
// One seed at a time; o_seed_stall is low only when idle. Output is registered.
// Reset (synchronous, active low) clears control, rng state and sets row count 64.
module seeded_permutation_generator import spg_pkg::*; #(
    parameter int MAX_ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_seed_valid,
    output logic        o_seed_stall,
    input  logic [63:0] i_seed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_position_value,
    output logic        o_last
);
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_ADV, S_MA, S_MB, S_MOD, S_RD, S_WR, S_OUT, S_OWAIT
    } t_state;

    t_state      r_state;
    logic [6:0]  r_row_count;
    logic [63:0] r_rng;
    logic [63:0] r_z;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_upper;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_pick;
    logic [5:0]  r_val_top;
    logic [5:0]  r_val_pick;
    logic        r_rd_phase;
    logic        r_valid;
    logic [5:0]  r_pos;
    logic        r_last;
    logic [5:0]  r_mem [MAX_ROWS];
    logic [5:0]  r_rdata;

    logic        w_mul_start;
    logic [63:0] w_mul_a;
    logic [63:0] w_mul_b;
    logic        w_mul_done;
    logic [63:0] w_mul_p;
    logic        w_mod_start;
    logic        w_mod_done;
    logic [CW-1:0] w_mod_rem;
    logic [CW-1:0] w_ncfg;
    logic        w_accept;

    assign w_ncfg = ({25'd0, r_row_count} > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(r_row_count);
    assign w_accept = i_seed_valid && (r_state == S_IDLE);
    assign o_seed_stall = (r_state != S_IDLE);

    // shared multiplier: mix constant A on first pass, B on second (fed from first product)
    assign w_mul_a = (r_state == S_ADV) ? (r_z ^ (r_z >> 30)) : (w_mul_p ^ (w_mul_p >> 27));
    assign w_mul_b = (r_state == S_ADV) ? MIX_MUL_A : MIX_MUL_B;
    assign w_mul_start = (r_state == S_ADV) || (r_state == S_MA && w_mul_done);
    assign w_mod_start = (r_state == S_MB) && w_mul_done;

    spg_mul64 u_mul (
        .i_clk, .i_rst_n, .i_start(w_mul_start), .i_a(w_mul_a), .i_b(w_mul_b),
        .o_done(w_mul_done), .o_p(w_mul_p)
    );

    spg_mod64 #(.DW(CW)) u_mod (
        .i_clk, .i_rst_n, .i_start(w_mod_start), .i_num(w_mul_p ^ (w_mul_p >> 31)),
        .i_den(r_upper), .o_done(w_mod_done), .o_rem(w_mod_rem)
    );

    // table port: one write, one registered read per cycle
    // swap writes: pick slot takes the old top first, then top takes the old pick
    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL && r_idx < r_n)
            r_mem[r_idx[AW-1:0]] <= 6'(r_idx);
        else if (r_state == S_WR)
            r_mem[r_rd_phase ? AW'(r_upper - 1'b1) : r_pick] <=
                r_rd_phase ? r_val_pick : r_val_top;
        r_rdata <= r_mem[(r_state == S_OUT || r_state == S_OWAIT) ? r_idx[AW-1:0] :
                         (r_rd_phase ? r_pick : AW'(r_upper - 1'b1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= 7'd64;
            r_rng       <= '0;
            r_valid     <= 1'b0;
            r_rd_phase  <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_row_count <= i_cfg_wdata;
            // S_OWAIT sets or holds the output itself
            if (r_valid && !i_stall && r_state != S_OWAIT)
                r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rng   <= i_seed;
                        r_n     <= w_ncfg;
                        r_upper <= w_ncfg;
                        r_idx   <= '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (r_idx >= r_n) begin
                        r_idx <= '0;
                        if (r_n == '0)
                            r_state <= S_IDLE;
                        else if (r_upper > 1) begin
                            r_z     <= r_rng + GOLDEN_STEP;
                            r_rng   <= r_rng + GOLDEN_STEP;
                            r_state <= S_ADV;
                        end else
                            r_state <= S_OUT;
                    end else
                        r_idx <= r_idx + 1'b1;
                end
                S_ADV: r_state <= S_MA;
                S_MA: begin
                    if (w_mul_done) begin
                        r_z     <= w_mul_p;
                        r_state <= S_MB;
                    end
                end
                S_MB: if (w_mul_done) r_state <= S_MOD;
                S_MOD: begin
                    if (w_mod_done) begin
                        r_pick     <= w_mod_rem[AW-1:0];
                        r_rd_phase <= 1'b0;
                        r_state    <= S_RD;
                    end
                end
                S_RD: begin
                    // read top, then pick (registered reads)
                    if (r_rd_phase) begin
                        r_val_top  <= r_rdata;
                        r_rd_phase <= 1'b0;
                        r_state    <= S_WR;
                    end else
                        r_rd_phase <= 1'b1;
                end
                S_WR: begin
                    if (!r_rd_phase) begin
                        r_val_pick <= r_rdata;
                        r_rd_phase <= 1'b1;
                    end else begin
                        r_rd_phase <= 1'b0;
                        r_upper    <= r_upper - 1'b1;
                        if (r_upper - 1'b1 > 1) begin
                            r_z     <= r_rng + GOLDEN_STEP;
                            r_rng   <= r_rng + GOLDEN_STEP;
                            r_state <= S_ADV;
                        end else
                            r_state <= S_OUT;
                    end
                end
                S_OUT: r_state <= S_OWAIT; // read latency
                S_OWAIT: begin
                    if (!r_valid || !i_stall) begin
                        r_valid <= 1'b1;
                        r_pos   <= r_rdata;
                        r_last  <= (r_idx + 1'b1 == r_n);
                        r_idx   <= r_idx + 1'b1;
                        r_state <= (r_idx + 1'b1 == r_n) ? S_IDLE : S_OUT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_position_value = r_pos;
    assign o_last           = r_last;

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_seed_stall) else $error("accepted while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_position_value)))
        else $error("output dropped");
    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_upper > 1)) else $error("bad upper");
endmodule

/* rtl/core/spg_mul64.sv */
// 64x64 -> low 64 bit multiplier, 16x64 partial product per cycle.
module spg_mul64 import spg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);
    logic [63:0] r_acc;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [79:0] w_pp;

    assign w_pp = {64'd0, r_b[15:0]} * {16'd0, r_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc <= r_acc + w_pp[63:0];
                r_a   <= {r_a[47:0], 16'd0};
                r_b   <= {16'd0, r_b[63:16]};
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

/* rtl/core/spg_mod64.sv */
// 64-bit modulo by small divisor, restoring, one bit a cycle.
module spg_mod64 import spg_pkg::*; #(
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_rem
);
    logic [63:0]   r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [6:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_sh;

    assign w_sh = {r_rem, r_num[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], 1'b0};
                if (w_sh >= {1'b0, r_den})
                    r_rem <= DW'(w_sh - {1'b0, r_den});
                else
                    r_rem <= w_sh[DW-1:0];
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

/* sim/seeded_permutation_generator_test.sv */
module seeded_permutation_generator_test;
    import spg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 64;
    localparam int IDLE_LIMIT  = 20000;     // longest quiet stretch before the watchdog fires
    localparam int DRAIN_WAIT  = 200;

    typedef struct packed {
        logic [5:0] position_value;
        logic       last;
    } t_perm_entry;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        i_seed_valid;
    logic        o_seed_stall;
    logic [63:0] i_seed;
    logic        o_valid;
    logic        i_stall;
    logic [5:0]  o_position_value;
    logic        o_last;

    // predictor copy of the row count register
    logic [6:0]  row_count_q;
    t_perm_entry perm_expected_q[$];
    int          fail_count;
    int          idle_cycles;
    // receiver behaviour knobs
    bit          hold_off;
    int          stall_pct;

    seeded_permutation_generator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_seed_valid     (i_seed_valid),
        .o_seed_stall     (o_seed_stall),
        .i_seed           (i_seed),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_position_value (o_position_value),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // SplitMix64 output for an already-advanced state
    function automatic logic [63:0] mix64(input logic [63:0] st);
        logic [63:0] z;
        z = st;
        z = (z ^ (z >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // Fisher-Yates from the seed; appends the permutation to the expected queue
    function automatic void predict_permutation(input logic [63:0] seed);
        logic [5:0]  order [TABLE_DEPTH];
        logic [63:0] st;
        logic [63:0] rnd;
        logic [5:0]  tmp;
        int          n;
        int          pick;
        t_perm_entry e;
        n  = (row_count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(row_count_q);
        st = seed;
        for (int i = 0; i < n; i++) order[i] = 6'(i);
        for (int up = n; up > 1; up--) begin
            st   = st + GOLDEN_STEP;
            rnd  = mix64(st);
            pick = int'(rnd % 64'(up));
            tmp           = order[up - 1];
            order[up - 1] = order[pick];
            order[pick]   = tmp;
        end
        for (int i = 0; i < n; i++) begin
            e.position_value = order[i];
            e.last           = (i == n - 1);
            perm_expected_q  = {perm_expected_q, e};
        end
    endfunction

    // one seed request; valid stays up across back-to-back requests
    task automatic send_seed(input logic [63:0] seed);
        i_seed_valid <= 1'b1;
        i_seed       <= seed;
        @(posedge i_clk);
        while (o_seed_stall) @(posedge i_clk);
        predict_permutation(seed);
    endtask

    task automatic seed_gap(input int cycles);
        if (cycles > 0) begin
            i_seed_valid <= 1'b0;
            i_seed       <= {$urandom, $urandom};
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        seed_gap(1);
        while (perm_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // only called once the block is idle
    task automatic write_row_count(input logic [6:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        row_count_q  = value;
    endtask

    // random seed, with an occasional all-zero or all-one seed
    function automatic logic [63:0] rand_seed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // bursts of random length, mostly followed by a random gap
    task automatic send_burst_mix(input int total);
        int sent;
        int burst;
        sent = 0;
        while (sent < total) begin
            burst = $urandom_range(1, 6);
            for (int k = 0; k < burst && sent < total; k++) begin
                send_seed(rand_seed());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) seed_gap($urandom_range(1, 40));
        end
    endtask

    // extremes of the seed and the row count, including the zero and one row cases
    task automatic test_directed();
        write_row_count(7'd0);
        send_seed(64'h0);
        send_seed('1);
        wait_drained();
        write_row_count(7'd1);
        send_seed(64'h0);
        send_seed('1);
        wait_drained();
        write_row_count(7'd2);
        send_seed(64'h0);
        send_seed(64'h8000_0000_0000_0001);
        send_seed(64'h5555_AAAA_5555_AAAA);
        wait_drained();
        // above the table depth saturates to 64 rows
        write_row_count(7'd127);
        send_seed(64'h0);
        wait_drained();
        write_row_count(7'd64);
        send_seed('1);
        send_seed(64'hAAAA_5555_AAAA_5555);
        wait_drained();
        write_row_count(7'd65);
        send_seed(64'h0123_4567_89AB_CDEF);
        wait_drained();
    endtask

    // receiver holds off for a long stretch while seeds keep coming
    task automatic test_backpressure();
        write_row_count(7'd5);
        hold_off = 1'b1;
        for (int k = 0; k < 6; k++) send_seed({$urandom, $urandom});
        hold_off = 1'b0;
        wait_drained();
    endtask

    // mostly small row counts (0 to 12), a few large ones (40 to 127, capped at 64)
    task automatic test_random_rows();
        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 4 == 3) write_row_count(7'($urandom_range(40, 127)));
            else write_row_count(7'($urandom_range(0, 12)));
            stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 70);
            send_burst_mix((ph % 4 == 3) ? 4 : 13);
            // sender pauses until every expected entry has come back
            wait_drained();
        end
    endtask

    // receiver stall pattern; a long counted stretch while hold_off is set
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                i_stall <= 1'b0;
                while (hold_off) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // result checker
    initial begin
        t_perm_entry want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (perm_expected_q.size() == 0) begin
                    $error("unexpected entry value=%0d last=%0b", o_position_value, o_last);
                    fail_count++;
                end else begin
                    want = perm_expected_q.pop_front();
                    if (o_position_value !== want.position_value) begin
                        $error("position_value expected %0d got %0d",
                               want.position_value, o_position_value);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last expected %0b got %0b", want.last, o_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on quiet cycles
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((o_valid && !i_stall) || (i_seed_valid && !o_seed_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        fail_count   = 0;
        hold_off     = 1'b0;
        stall_pct    = 30;
        row_count_q  = 7'd64;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_seed_valid = 1'b0;
        i_seed       = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_rows();

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
